// ===== sv/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths and register indexes shared by the ray-sphere intersection block.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int CoordW = 32;
    localparam int RadW   = 31;
    localparam int LW     = 33;
    localparam int ProdW  = 66;
    localparam int D2W    = 66;
    localparam int PW     = 67;
    localparam int PrW    = 38;
    localparam int PHiW   = 19;
    localparam int PLoW   = 19;
    localparam int PsqW   = 76;
    localparam int HW     = 78;
    localparam int SqB    = 37;
    localparam int TW     = 39;
    localparam int R2W    = 62;
    localparam int IdxW   = 3;

    localparam logic [IdxW-1:0] REG_CENTER_X = 3'd0;
    localparam logic [IdxW-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [IdxW-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [IdxW-1:0] REG_RADIUS   = 3'd3;

endpackage

// ===== sv/ray_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Geometric ray-sphere test in fixed point with a one-bit-per-stage square root.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Moves
//  input     s_valid / s_ready             ray origin, direction, t interval
//  result    m_valid / m_ready             hit flag and chosen t
//  config    cfg_we, cfg_index, cfg_wdata  sphere center and radius
//
// One transaction enters per cycle while the pipeline advances; there are seven
// arithmetic stages, 37 square-root stages and the output register.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears the valid bits and sets the sphere to the origin with radius 1.0.
// ----------------------------------------------------------------------------
module ray_sphere_intersect (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rsi_pkg::IdxW-1:0]       cfg_index,
    input  logic [rsi_pkg::CoordW-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [rsi_pkg::CoordW-1:0] s_origin_x,
    input  logic signed [rsi_pkg::CoordW-1:0] s_origin_y,
    input  logic signed [rsi_pkg::CoordW-1:0] s_origin_z,
    input  logic signed [rsi_pkg::CoordW-1:0] s_dir_x,
    input  logic signed [rsi_pkg::CoordW-1:0] s_dir_y,
    input  logic signed [rsi_pkg::CoordW-1:0] s_dir_z,
    input  logic signed [rsi_pkg::CoordW-1:0] s_t_min,
    input  logic signed [rsi_pkg::CoordW-1:0] s_t_max,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit,
    output logic signed [rsi_pkg::CoordW-1:0] m_t_hit
);

    localparam int CW  = rsi_pkg::CoordW;
    localparam int LW  = rsi_pkg::LW;
    localparam int SQB = rsi_pkg::SqB;
    localparam int HW  = rsi_pkg::HW;
    localparam int TW  = rsi_pkg::TW;

    logic signed [CW-1:0]            cx_reg, cy_reg, cz_reg;
    logic [rsi_pkg::RadW-1:0]        rad_reg;
    logic [rsi_pkg::R2W-1:0]         r2_reg;
    logic                            adv;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= rsi_pkg::RadW'(65536);
        end else if (cfg_we) begin
            case (cfg_index)
                rsi_pkg::REG_CENTER_X: cx_reg  <= cfg_wdata;
                rsi_pkg::REG_CENTER_Y: cy_reg  <= cfg_wdata;
                rsi_pkg::REG_CENTER_Z: cz_reg  <= cfg_wdata;
                rsi_pkg::REG_RADIUS:   rad_reg <= cfg_wdata[rsi_pkg::RadW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        r2_reg <= rsi_pkg::R2W'(rad_reg * rad_reg);
    end

    // Stage 1: vector from origin to center.
    logic                   v1_reg;
    logic signed [LW-1:0]   lx_reg, ly_reg, lz_reg;
    logic signed [CW-1:0]   dx_reg, dy_reg, dz_reg, tmin1_reg, tmax1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_valid;
        if (adv) begin
            lx_reg    <= LW'(cx_reg) - LW'(s_origin_x);
            ly_reg    <= LW'(cy_reg) - LW'(s_origin_y);
            lz_reg    <= LW'(cz_reg) - LW'(s_origin_z);
            dx_reg    <= s_dir_x;
            dy_reg    <= s_dir_y;
            dz_reg    <= s_dir_z;
            tmin1_reg <= s_t_min;
            tmax1_reg <= s_t_max;
        end
    end

    // Stage 2: products.
    logic                                  v2_reg;
    logic signed [rsi_pkg::ProdW-1:0]      qx_reg, qy_reg, qz_reg, ux_reg, uy_reg, uz_reg;
    logic signed [CW-1:0]                  tmin2_reg, tmax2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            qx_reg    <= lx_reg * lx_reg;
            qy_reg    <= ly_reg * ly_reg;
            qz_reg    <= lz_reg * lz_reg;
            ux_reg    <= lx_reg * LW'(dx_reg);
            uy_reg    <= ly_reg * LW'(dy_reg);
            uz_reg    <= lz_reg * LW'(dz_reg);
            tmin2_reg <= tmin1_reg;
            tmax2_reg <= tmax1_reg;
        end
    end

    // Stage 3: squared distance and projection.
    logic                               v3_reg;
    logic [rsi_pkg::D2W-1:0]            d2_3_reg;
    logic signed [rsi_pkg::PW-1:0]      pp_reg;
    logic signed [CW-1:0]               tmin3_reg, tmax3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
        if (adv) begin
            d2_3_reg  <= rsi_pkg::D2W'($unsigned(qx_reg)) + rsi_pkg::D2W'($unsigned(qy_reg))
                       + rsi_pkg::D2W'($unsigned(qz_reg));
            pp_reg    <= rsi_pkg::PW'(ux_reg) + rsi_pkg::PW'(uy_reg) + rsi_pkg::PW'(uz_reg);
            tmin3_reg <= tmin2_reg;
            tmax3_reg <= tmax2_reg;
        end
    end

    // Stage 4: outside-and-away test and rounded projection.
    logic                               v4_reg, away4_reg;
    logic [rsi_pkg::D2W-1:0]            d2_4_reg;
    logic signed [rsi_pkg::PrW-1:0]     p4_reg;
    logic signed [CW-1:0]               tmin4_reg, tmax4_reg;
    logic signed [rsi_pkg::PW-1:0]      pround;

    assign pround = pp_reg + rsi_pkg::PW'(64'sd536870912);

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            away4_reg <= (rsi_pkg::D2W'(r2_reg) < d2_3_reg) && pp_reg[rsi_pkg::PW-1];
            d2_4_reg  <= d2_3_reg;
            p4_reg    <= rsi_pkg::PrW'(pround >>> 30);
            tmin4_reg <= tmin3_reg;
            tmax4_reg <= tmax3_reg;
        end
    end

    // Stage 5: partial products of the rounded projection, split into a signed
    // upper half and an unsigned lower half.
    logic                                        v5_reg, away5_reg;
    logic [rsi_pkg::D2W-1:0]                     d2_5_reg;
    logic signed [rsi_pkg::PrW-1:0]              p5_reg;
    logic signed [2*rsi_pkg::PHiW-1:0]           phh_reg;
    logic signed [rsi_pkg::PHiW+rsi_pkg::PLoW:0] phl_reg;
    logic [2*rsi_pkg::PLoW-1:0]                  pll_reg;
    logic signed [CW-1:0]                        tmin5_reg, tmax5_reg;
    logic signed [rsi_pkg::PHiW-1:0]             p_hi;
    logic signed [rsi_pkg::PLoW:0]               p_lo;

    assign p_hi = p4_reg[rsi_pkg::PrW-1:rsi_pkg::PLoW];
    assign p_lo = $signed({1'b0, p4_reg[rsi_pkg::PLoW-1:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
        if (adv) begin
            away5_reg <= away4_reg;
            d2_5_reg  <= d2_4_reg;
            p5_reg    <= p4_reg;
            phh_reg   <= p_hi * p_hi;
            phl_reg   <= p_hi * p_lo;
            pll_reg   <= p4_reg[rsi_pkg::PLoW-1:0] * p4_reg[rsi_pkg::PLoW-1:0];
            tmin5_reg <= tmin4_reg;
            tmax5_reg <= tmax4_reg;
        end
    end

    // Stage 6: square of the rounded projection.
    logic                               v6_reg, away6_reg;
    logic [rsi_pkg::D2W-1:0]            d2_6_reg;
    logic signed [rsi_pkg::PrW-1:0]     p6_reg;
    logic signed [rsi_pkg::PsqW-1:0]    psq_reg;
    logic signed [CW-1:0]               tmin6_reg, tmax6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (adv) v6_reg <= v5_reg;
        if (adv) begin
            away6_reg <= away5_reg;
            d2_6_reg  <= d2_5_reg;
            p6_reg    <= p5_reg;
            psq_reg   <= (rsi_pkg::PsqW'(phh_reg) <<< (2 * rsi_pkg::PLoW))
                       + (rsi_pkg::PsqW'(phl_reg) <<< (rsi_pkg::PLoW + 1))
                       + rsi_pkg::PsqW'($signed({1'b0, pll_reg}));
            tmin6_reg <= tmin5_reg;
            tmax6_reg <= tmax5_reg;
        end
    end

    // Stage 7: perpendicular distance test and radicand.
    logic signed [HW-1:0]   perp, r2s;
    logic                   v7_reg;

    assign perp = HW'($signed({1'b0, d2_6_reg})) - HW'(psq_reg);
    assign r2s  = HW'($signed({1'b0, r2_reg}));

    logic [HW-1:0]                   rem_reg   [0:SQB];
    logic [SQB-1:0]                  root_reg  [0:SQB];
    logic signed [rsi_pkg::PrW-1:0]  p_reg     [0:SQB];
    logic signed [CW-1:0]            tmin_reg  [0:SQB];
    logic signed [CW-1:0]            tmax_reg  [0:SQB];
    logic                            miss_reg  [0:SQB];
    logic                            vs_reg    [0:SQB];

    always_ff @(posedge aclk) begin
        if (!aresetn) vs_reg[0] <= 1'b0;
        else if (adv) vs_reg[0] <= v6_reg;
        if (adv) begin
            rem_reg[0]  <= $unsigned(r2s - perp);
            root_reg[0] <= '0;
            p_reg[0]    <= p6_reg;
            tmin_reg[0] <= tmin6_reg;
            tmax_reg[0] <= tmax6_reg;
            miss_reg[0] <= away6_reg || (r2s < perp);
        end
    end
    assign v7_reg = vs_reg[0];

    // Square root, one result bit per stage, most significant first.
    for (genvar k = 0; k < SQB; k++) begin : g_sqrt
        localparam int B = SQB - 1 - k;
        logic [HW-1:0] trial;
        logic          ge;

        assign trial = (HW'(root_reg[k]) << (B + 1)) | (HW'(1) << (2 * B));
        assign ge    = rem_reg[k] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) vs_reg[k+1] <= 1'b0;
            else if (adv) vs_reg[k+1] <= vs_reg[k];
            if (adv) begin
                rem_reg[k+1]  <= ge ? rem_reg[k] - trial : rem_reg[k];
                root_reg[k+1] <= ge ? (root_reg[k] | (SQB'(1) << B)) : root_reg[k];
                p_reg[k+1]    <= p_reg[k];
                tmin_reg[k+1] <= tmin_reg[k];
                tmax_reg[k+1] <= tmax_reg[k];
                miss_reg[k+1] <= miss_reg[k];
            end
        end
    end

    // Root selection and saturation.
    logic signed [TW-1:0]  t_near, t_far, lo, hi, t_sel;
    logic                  near_ok, far_ok, hit_next;
    logic signed [CW-1:0]  t_next;

    assign t_near  = TW'(p_reg[SQB]) - TW'($signed({1'b0, root_reg[SQB]}));
    assign t_far   = TW'(p_reg[SQB]) + TW'($signed({1'b0, root_reg[SQB]}));
    assign lo      = TW'(tmin_reg[SQB]);
    assign hi      = TW'(tmax_reg[SQB]);
    assign near_ok = (t_near >= lo) && (t_near <= hi);
    assign far_ok  = (t_far >= lo) && (t_far <= hi);
    assign hit_next = !miss_reg[SQB] && (near_ok || far_ok);
    assign t_sel   = near_ok ? t_near : t_far;

    always_comb begin
        if (!hit_next) begin
            t_next = '0;
        end else if (t_sel > TW'(64'sd2147483647)) begin
            t_next = 32'sh7FFFFFFF;
        end else if (t_sel < -TW'(64'sd2147483648)) begin
            t_next = 32'sh80000000;
        end else begin
            t_next = CW'(t_sel);
        end
    end

    logic m_valid_reg, m_hit_reg;
    logic signed [CW-1:0] m_t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (adv) m_valid_reg <= vs_reg[SQB];
        if (adv) begin
            m_hit_reg <= hit_next;
            m_t_reg   <= t_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;
    assign m_t_hit = m_t_reg;

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_t_hit == '0)
        else $error("miss carries a nonzero t");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid && !v7_reg)
        else $error("pipeline valid after reset");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vs_reg[SQB]) && $stable(root_reg[SQB]))
        else $error("square-root stage moved during stall");

endmodule

// ===== verif/tb_ray_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect
// Self-checking testbench for the fixed-point ray-sphere intersection block.
// A directed table covers the extremes and the miss cases. Aimed random rays
// and some raw noise then run under several sphere settings. Every result
// transaction is compared with its table entry or with a wide-precision predictor in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ray_sphere_intersect;

    localparam logic [rsi_pkg::IdxW-1:0] REG_UNUSED = 3'd7;
    localparam int WatchLimit = 5000;
    localparam int DrainCycles = 60;
    localparam int RandPerPhase = 80;

    typedef struct {
        logic signed [31:0] ox, oy, oz, dx, dy, dz, tmin, tmax;
        bit                 typed;
        logic               e_hit;
        logic signed [31:0] e_t;
    } ray_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] t;
    } hit_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [rsi_pkg::IdxW-1:0] cfg_index = '0;
    logic [rsi_pkg::CoordW-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [31:0] s_origin_x = 0, s_origin_y = 0, s_origin_z = 0;
    logic signed [31:0] s_dir_x = 0, s_dir_y = 0, s_dir_z = 0;
    logic signed [31:0] s_t_min = 0, s_t_max = 0;
    logic m_valid;
    logic m_ready = 0;
    logic m_hit;
    logic signed [31:0] m_t_hit;

    logic signed [63:0] sph_cx = 0, sph_cy = 0, sph_cz = 0, sph_r = 65536;
    hit_t expected_hits[$];
    int fails = 0;
    int watch = 0;
    bit calm = 0;
    int stall_left = 0;

    ray_sphere_intersect u_top (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function automatic hit_t sphere_hit(ray_t r);
        logic signed [63:0] lx, ly, lz, p, s, c, t;
        logic signed [127:0] d2, pp, r2, q, perp, h;
        hit_t res;
        res.hit = 0;
        res.t = 0;
        lx = sph_cx - r.ox;
        ly = sph_cy - r.oy;
        lz = sph_cz - r.oz;
        d2 = lx * lx + ly * ly + lz * lz;
        pp = lx * 64'(r.dx) + ly * 64'(r.dy) + lz * 64'(r.dz);
        r2 = sph_r * sph_r;
        if (r2 < d2 && pp < 0) return res;
        q = pp + (128'sd1 <<< 29);
        p = 64'(q >>> 30);
        perp = d2 - p * p;
        if (r2 < perp) return res;
        h = r2 - perp;
        s = 0;
        for (int b = 36; b >= 0; b--) begin
            c = s | (64'sd1 <<< b);
            if (h >= c * c) s = c;
        end
        t = p - s;
        if (!(t >= r.tmin && t <= r.tmax)) t = p + s;
        if (t >= r.tmin && t <= r.tmax) begin
            res.hit = 1;
            if (t > 64'sd2147483647) res.t = 32'sh7fffffff;
            else if (t < -64'sd2147483648) res.t = 32'sh80000000;
            else res.t = 32'(t);
        end
        return res;
    endfunction

    function automatic logic signed [31:0] to_fix(real x);
        if (x > 2147483647.0) return 32'sh7fffffff;
        if (x < -2147483648.0) return 32'sh80000000;
        return 32'(longint'(x));
    endfunction

    function automatic real urand_real(real span);
        return ($urandom_range(0, 2000000) / 1.0e6 - 1.0) * span;
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        real rr, span, ox, oy, oz, vx, vy, vz, len, a, b;
        r.typed = 0;
        r.e_hit = 0;
        r.e_t = 0;
        if ($urandom_range(0, 9) < 2) begin
            r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
            r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
            r.tmin = $urandom; r.tmax = $urandom;
            return r;
        end
        rr = sph_r / 65536.0;
        span = rr * 3.0 + 2.0;
        ox = sph_cx / 65536.0 + urand_real(span);
        oy = sph_cy / 65536.0 + urand_real(span);
        oz = sph_cz / 65536.0 + urand_real(span);
        vx = sph_cx / 65536.0 + urand_real(rr * 1.2) - ox;
        vy = sph_cy / 65536.0 + urand_real(rr * 1.2) - oy;
        vz = sph_cz / 65536.0 + urand_real(rr * 1.2) - oz;
        len = $sqrt(vx * vx + vy * vy + vz * vz);
        if (len < 1.0e-6) begin
            vx = 0.0; vy = 0.0; vz = 1.0; len = 1.0;
        end
        if ($urandom_range(0, 3) == 0) len = -len;
        r.ox = to_fix(ox * 65536.0);
        r.oy = to_fix(oy * 65536.0);
        r.oz = to_fix(oz * 65536.0);
        r.dx = to_fix(vx / len * 1073741824.0);
        r.dy = to_fix(vy / len * 1073741824.0);
        r.dz = to_fix(vz / len * 1073741824.0);
        a = ($urandom_range(0, 1) == 1) ? 0.0 : urand_real(span * 2.0);
        b = ($urandom_range(0, 1) == 1) ? span * 3.0 : urand_real(span * 3.0);
        r.tmin = to_fix(a * 65536.0);
        r.tmax = to_fix(b * 65536.0);
        return r;
    endfunction

    task automatic write_reg(logic [rsi_pkg::IdxW-1:0] idx, logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        case (idx)
            rsi_pkg::REG_CENTER_X: sph_cx = 64'(signed'(val));
            rsi_pkg::REG_CENTER_Y: sph_cy = 64'(signed'(val));
            rsi_pkg::REG_CENTER_Z: sph_cz = 64'(signed'(val));
            rsi_pkg::REG_RADIUS:   sph_r = 64'(val[30:0]);
            default: ;
        endcase
    endtask

    task automatic send_ray(ray_t r);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1;
        s_origin_x <= r.ox; s_origin_y <= r.oy; s_origin_z <= r.oz;
        s_dir_x <= r.dx; s_dir_y <= r.dy; s_dir_z <= r.dz;
        s_t_min <= r.tmin; s_t_max <= r.tmax;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (r.typed) expected_hits.push_back(hit_t'{r.e_hit, r.e_t});
        else expected_hits.push_back(sphere_hit(r));
    endtask

    task automatic drain();
        s_valid <= 0;
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result transaction hit=%0b t_hit=%0d",
                         $time, m_hit, m_t_hit);
                fails++;
            end else begin
                hit_t e;
                e = expected_hits.pop_front();
                if (m_hit !== e.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, e.hit, m_hit);
                    fails++;
                end
                if (m_t_hit !== e.t) begin
                    $display("%0t: t_hit expected %0d actual %0d", $time, e.t, m_t_hit);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (calm) m_ready <= 1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_ready <= 0;
        end else m_ready <= 1;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) watch <= 0;
        else watch <= watch + 1;
        if (watch >= WatchLimit) begin
            $display("ray_sphere_intersect verification failed");
            $finish;
        end
    end

    initial begin
        ray_t table_rows[$];
        logic signed [31:0] ONE, DMAX, DMIN;
        ONE = 32'sd65536;
        DMAX = 32'sd1073741824;
        DMIN = -32'sd1073741824;
        // Unit sphere at the origin; most rays run along z.
        table_rows = '{
            '{0, 0, -5 * ONE, 0, 0, DMAX, 0, 100 * ONE, 1, 1, 4 * ONE},
            '{0, 0, -5 * ONE, 0, 0, DMAX, 100 * ONE, 0, 1, 0, 0},
            '{0, 0, -5 * ONE, 0, 0, DMIN, 0, 100 * ONE, 1, 0, 0},
            '{0, 0, 0, 0, 0, DMAX, -10 * ONE, 10 * ONE, 1, 1, -ONE},
            '{0, 0, 0, 0, 0, DMAX, 0, 10 * ONE, 1, 1, ONE},
            '{0, 0, 0, 0, 0, DMAX, 2 * ONE, 10 * ONE, 1, 0, 0},
            '{0, 5 * ONE, -5 * ONE, 0, 0, DMAX, 0, 100 * ONE, 1, 0, 0},
            '{ONE, 0, -5 * ONE, 0, 0, DMAX, 0, 100 * ONE, 0, 0, 0},
            '{0, 0, 5 * ONE, DMIN, DMAX, DMIN, 32'sh80000000, 32'sh7fffffff, 0, 0, 0},
            '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0},
            '{32'sh80000000, 32'sh80000000, 32'sh80000000, DMAX, DMAX, DMAX,
              32'sh80000000, 32'sh7fffffff, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 0, 0, 0},
            '{-3 * ONE, -3 * ONE, 0, DMAX / 2, DMAX / 2, 0, 0, 50 * ONE, 0, 0, 0},
            '{0, 0, -5 * ONE, 0, 0, DMAX, 4 * ONE, 4 * ONE, 1, 1, 4 * ONE},
            '{0, 0, -5 * ONE, 0, 0, DMAX, 6 * ONE, 6 * ONE, 1, 1, 6 * ONE}
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (table_rows[i]) send_ray(table_rows[i]);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(rsi_pkg::REG_CENTER_X, 0);
                    write_reg(rsi_pkg::REG_CENTER_Y, 0);
                    write_reg(rsi_pkg::REG_CENTER_Z, 0);
                    write_reg(rsi_pkg::REG_RADIUS, 0);
                end
                1: begin
                    write_reg(rsi_pkg::REG_CENTER_X, 32'h7fffffff);
                    write_reg(rsi_pkg::REG_CENTER_Y, 32'h80000000);
                    write_reg(rsi_pkg::REG_CENTER_Z, 32'h7fffffff);
                    write_reg(rsi_pkg::REG_RADIUS, 32'h7fffffff);
                end
                2: begin
                    write_reg(rsi_pkg::REG_CENTER_X, 32'h80000000);
                    write_reg(rsi_pkg::REG_CENTER_Y, 32'h7fffffff);
                    write_reg(rsi_pkg::REG_CENTER_Z, 32'h80000000);
                    write_reg(rsi_pkg::REG_RADIUS, 32'h40000000);
                end
                default: begin
                    write_reg(rsi_pkg::REG_CENTER_X,
                              32'($signed($urandom_range(0, 40 << 16)) - (20 << 16)));
                    write_reg(rsi_pkg::REG_CENTER_Y,
                              32'($signed($urandom_range(0, 40 << 16)) - (20 << 16)));
                    write_reg(rsi_pkg::REG_CENTER_Z,
                              32'($signed($urandom_range(0, 40 << 16)) - (20 << 16)));
                    write_reg(rsi_pkg::REG_RADIUS, $urandom_range(1, 8 << 16) | 32'h80000000);
                    write_reg(REG_UNUSED, $urandom);
                end
            endcase
            calm = (ph == 4);
            for (int n = 0; n < RandPerPhase; n++) send_ray(random_ray());
            drain();
        end

        if (fails == 0) $display("ray_sphere_intersect verification clean");
        else $display("ray_sphere_intersect verification failed");
        $finish;
    end

endmodule
